@@ sv/asgr_pkg.sv @@
// ----------------------------------------------------------------------------
// asgr_pkg
// Shared types and character codes for the SGR attribute parser.
// ----------------------------------------------------------------------------
package asgr_pkg;

    localparam int CHAR_W  = 8;
    localparam int ACC_W   = 7;
    localparam int COLOR_W = 3;

    // character codes
    localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_SEMI     = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_M        = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_NL       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_0        = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9        = 8'h39;

    // SGR parameter codes
    localparam logic [ACC_W-1:0] ACC_MAX    = 7'd127;
    localparam logic [ACC_W-1:0] SGR_RESET  = 7'd0;
    localparam logic [ACC_W-1:0] SGR_BOLD   = 7'd1;
    localparam logic [ACC_W-1:0] SGR_FG_LOW  = 7'd30;
    localparam logic [ACC_W-1:0] SGR_FG_HIGH = 7'd37;
    localparam logic [ACC_W-1:0] SGR_BG_LOW  = 7'd40;
    localparam logic [ACC_W-1:0] SGR_BG_HIGH = 7'd47;

    // one colour selection: sel set once a colour has been chosen
    typedef struct packed {
        logic               sel;
        logic [COLOR_W-1:0] idx;
    } color_t;

    // parser and attribute state
    typedef struct packed {
        logic             in_sequence;
        logic             just_after_escape;
        logic [ACC_W-1:0] param_accum;
        logic             param_has_digit;
        logic             param_bad;
        logic             bold_flag;
        color_t           fg;
        color_t           bg;
    } state_t;

    // one result item
    typedef struct packed {
        logic [CHAR_W-1:0]  char_out;
        logic               is_bold;
        logic               fg_valid;
        logic [COLOR_W-1:0] fg_colour;
        logic               bg_valid;
        logic [COLOR_W-1:0] bg_colour;
        logic               line_end;
    } result_t;

endpackage

@@ sv/asgr_in_if.sv @@
// ----------------------------------------------------------------------------
// asgr_in_if
// Byte input channel: valid/ready handshake carrying one text byte.
// ----------------------------------------------------------------------------
interface asgr_in_if;

    logic                          valid;
    logic                          ready;
    logic [asgr_pkg::CHAR_W-1:0]   char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);

endinterface

@@ sv/asgr_out_if.sv @@
// ----------------------------------------------------------------------------
// asgr_out_if
// Result channel: valid/ready handshake carrying a byte and its attributes.
// ----------------------------------------------------------------------------
interface asgr_out_if;

    logic                          valid;
    logic                          ready;
    logic [asgr_pkg::CHAR_W-1:0]   char_out;
    logic                          is_bold;
    logic                          fg_valid;
    logic [asgr_pkg::COLOR_W-1:0]  fg_colour;
    logic                          bg_valid;
    logic [asgr_pkg::COLOR_W-1:0]  bg_colour;
    logic                          line_end;

    modport source (output valid, output char_out, output is_bold, output fg_valid,
                    output fg_colour, output bg_valid, output bg_colour,
                    output line_end, input ready);
    modport sink   (input valid, input char_out, input is_bold, input fg_valid,
                    input fg_colour, input bg_valid, input bg_colour,
                    input line_end, output ready);

endinterface

@@ sv/ansi_sgr_attribute_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ansi_sgr_attribute_parser_unit
// Terminal byte stream parser that tracks SGR bold/colour attributes.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                        | handshake
//  byte_in   | in  | char_in[7:0]                                   | valid/ready
//  attr_out  | out | char_out, is_bold, fg_valid/colour, bg_valid/  | valid/ready
//            |     | colour, line_end                               |
//
//  One byte per cycle sustained while the result register is not stalled.
//  The byte sits in an input register; the decode and state update run when it
//  moves on, writing the result register. Escape bytes and sequence bytes give
//  no result. A stalled result register holds the input register, which still
//  takes a byte while empty. Reset clears attributes and sequence state.
// ----------------------------------------------------------------------------
module ansi_sgr_attribute_parser_unit (
    input  logic            clk,
    input  logic            rst_n,
    asgr_in_if.sink         byte_in,
    asgr_out_if.source      attr_out
);

    logic                          s1_valid_reg;
    logic [asgr_pkg::CHAR_W-1:0]   s1_char_reg;
    asgr_pkg::state_t              state_reg;
    asgr_pkg::state_t              state_next;
    asgr_pkg::result_t             res_next;
    asgr_pkg::result_t             res_reg;
    logic                          out_valid_reg;
    logic                          has_result;
    logic                          advance;

    // stage 1 moves on whenever the result register is free or being taken
    assign advance       = !out_valid_reg || attr_out.ready;
    assign byte_in.ready = !s1_valid_reg || advance;

    asgr_step u_step (
        .char_in    (s1_char_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (res_next),
        .has_result (has_result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            s1_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            s1_char_reg <= byte_in.char_in;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && has_result)
        begin
            res_reg <= res_next;
        end
    end

    assign attr_out.valid     = out_valid_reg;
    assign attr_out.char_out  = res_reg.char_out;
    assign attr_out.is_bold   = res_reg.is_bold;
    assign attr_out.fg_valid  = res_reg.fg_valid;
    assign attr_out.fg_colour = res_reg.fg_colour;
    assign attr_out.bg_valid  = res_reg.bg_valid;
    assign attr_out.bg_colour = res_reg.bg_colour;
    assign attr_out.line_end  = res_reg.line_end;

    // a processed newline leaves no open sequence and no attributes
    a_nl_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && s1_char_reg == asgr_pkg::CH_NL
        |=> !state_reg.in_sequence && !state_reg.bold_flag && !state_reg.fg.sel
            && !state_reg.bg.sel)
        else $error("newline did not clear parser state");

    // a line-end result carries no byte and no attributes
    a_line_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.line_end
        |-> res_reg.char_out == '0 && !res_reg.is_bold && !res_reg.fg_valid
            && !res_reg.bg_valid)
        else $error("line-end result carries attributes");

    // stalled stage 1 keeps its byte
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_char_reg))
        else $error("stage 1 byte lost under stall");

    // state changes only when a byte is processed
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && advance) |=> $stable(state_reg))
        else $error("parser state changed without a byte");

endmodule

@@ sv/asgr_step.sv @@
// ----------------------------------------------------------------------------
// asgr_step
// Per-byte decode: next parser state and the optional result for one byte.
// ----------------------------------------------------------------------------
module asgr_step (
    input  logic [asgr_pkg::CHAR_W-1:0] char_in,
    input  asgr_pkg::state_t            state,
    output asgr_pkg::state_t            state_next,
    output asgr_pkg::result_t           result,
    output logic                        has_result
);

    logic                         is_digit;
    logic [3:0]                   digit;
    logic [10:0]                  acc_prod;
    logic [asgr_pkg::ACC_W-1:0]   acc_sat;
    asgr_pkg::state_t             applied;

    // digit classification and saturating decimal accumulate
    assign is_digit = (char_in >= asgr_pkg::CH_0) && (char_in <= asgr_pkg::CH_9);
    assign digit    = 4'(char_in - asgr_pkg::CH_0);
    assign acc_prod = 11'({4'd0, state.param_accum} * 11'd10) + {7'd0, digit};
    assign acc_sat  = (acc_prod > {4'd0, asgr_pkg::ACC_MAX}) ? asgr_pkg::ACC_MAX
                                                            : acc_prod[asgr_pkg::ACC_W-1:0];

    // state after applying the pending parameter at a terminator
    always_comb
    begin
        applied = state;
        if (state.param_has_digit && !state.param_bad)
        begin
            if (state.param_accum == asgr_pkg::SGR_RESET)
            begin
                applied.bold_flag = 1'b0;
                applied.fg        = '0;
                applied.bg        = '0;
            end
            else if (state.param_accum == asgr_pkg::SGR_BOLD)
            begin
                applied.bold_flag = 1'b1;
            end
            else if (state.param_accum >= asgr_pkg::SGR_FG_LOW &&
                     state.param_accum <= asgr_pkg::SGR_FG_HIGH)
            begin
                applied.fg.sel = 1'b1;
                applied.fg.idx = asgr_pkg::COLOR_W'(state.param_accum - asgr_pkg::SGR_FG_LOW);
            end
            else if (state.param_accum >= asgr_pkg::SGR_BG_LOW &&
                     state.param_accum <= asgr_pkg::SGR_BG_HIGH)
            begin
                applied.bg.sel = 1'b1;
                applied.bg.idx = asgr_pkg::COLOR_W'(state.param_accum - asgr_pkg::SGR_BG_LOW);
            end
        end
        applied.param_accum     = '0;
        applied.param_has_digit = 1'b0;
        applied.param_bad       = 1'b0;
    end

    // byte dispatch
    always_comb
    begin
        state_next = state;
        has_result = 1'b0;
        result     = '0;
        if (char_in == asgr_pkg::CH_NL)
        begin
            // newline clears everything and marks a line end
            state_next      = '0;
            has_result      = 1'b1;
            result.line_end = 1'b1;
        end
        else if (!state.in_sequence)
        begin
            if (char_in == asgr_pkg::CH_ESC)
            begin
                state_next.in_sequence       = 1'b1;
                state_next.just_after_escape = 1'b1;
                state_next.param_accum       = '0;
                state_next.param_has_digit   = 1'b0;
                state_next.param_bad         = 1'b0;
            end
            else
            begin
                has_result       = 1'b1;
                result.char_out  = char_in;
                result.is_bold   = state.bold_flag;
                result.fg_valid  = state.fg.sel;
                result.fg_colour = state.fg.sel ? state.fg.idx : '0;
                result.bg_valid  = state.bg.sel;
                result.bg_colour = state.bg.sel ? state.bg.idx : '0;
            end
        end
        else
        begin
            state_next.just_after_escape = 1'b0;
            if (state.just_after_escape && char_in == asgr_pkg::CH_LBRACKET)
            begin
                // introducer bracket is skipped
            end
            else if (is_digit)
            begin
                state_next.param_accum     = acc_sat;
                state_next.param_has_digit = 1'b1;
            end
            else if (char_in == asgr_pkg::CH_SEMI)
            begin
                state_next                   = applied;
                state_next.just_after_escape = 1'b0;
            end
            else if (char_in == asgr_pkg::CH_M)
            begin
                state_next                   = applied;
                state_next.just_after_escape = 1'b0;
                state_next.in_sequence       = 1'b0;
            end
            else
            begin
                state_next.param_bad = 1'b1;
            end
        end
    end

endmodule
